@@ hw/rtl/i2cmts_pkg.sv @@
// shared types, codes and field layout of the i2c master transfer sequencer
// used by the decision logic, the top level and the port checker
package i2cmts_pkg;

  // write buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  // bus widths
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 32;
  localparam int CNT_W    = 9;

  // item kinds carried on s_tuser
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_IRQ   = 2'd2;

  // stored transfer directions
  localparam logic [1:0] DIR_READ  = 2'd1;
  localparam logic [1:0] DIR_WRITE = 2'd2;

  // controller status codes
  localparam logic [7:0] ST_START_SENT  = 8'h08;
  localparam logic [7:0] ST_WADDR_ACK   = 8'h18;
  localparam logic [7:0] ST_WADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_WDATA_ACK   = 8'h28;
  localparam logic [7:0] ST_WDATA_NACK  = 8'h30;
  localparam logic [7:0] ST_RADDR_ACK   = 8'h40;
  localparam logic [7:0] ST_RADDR_NACK  = 8'h48;
  localparam logic [7:0] ST_RDATA_ACK   = 8'h50;
  localparam logic [7:0] ST_RDATA_NACK  = 8'h58;

  // byte kinds carried on m_tuser
  localparam logic [1:0] BK_NONE = 2'd0;
  localparam logic [1:0] BK_SEND = 2'd1;
  localparam logic [1:0] BK_RECV = 2'd2;

  // acknowledge control
  localparam logic [1:0] AA_LEAVE = 2'd0;
  localparam logic [1:0] AA_SET   = 2'd1;
  localparam logic [1:0] AA_CLEAR = 2'd2;

  // transfer outcomes
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_NOREPLY = 2'd1;
  localparam logic [1:0] OUT_BUSY    = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one input item
  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       index;
    logic [7:0]       data_byte;
    logic [7:0]       slave_address;
    logic [CNT_W-1:0] length;
    logic [1:0]       direction;
    logic             irq_flag;
    logic [7:0]       status_code;
  } item_t;

  // transfer context kept between items
  typedef struct packed {
    logic [CNT_W-1:0] byte_counter;
    logic [CNT_W-1:0] stored_length;
    logic [7:0]       stored_address;
    logic [1:0]       stored_direction;
  } ctx_t;

  // one result, use_mem selects the buffer read data as byte_value
  typedef struct packed {
    logic             handled;
    logic [1:0]       byte_kind;
    logic [7:0]       byte_value;
    logic [7:0]       byte_index;
    logic             clear_all;
    logic             set_start;
    logic             clear_start;
    logic             clear_irq;
    logic             set_stop;
    logic [1:0]       ack_control;
    logic             done_res;
    logic [1:0]       outcome;
    logic             use_mem;
  } res_t;

  // write buffer access for one item
  typedef struct packed {
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
  } mem_req_t;

endpackage

@@ hw/rtl/i2c_master_transfer_sequencer.sv @@
// top level of the i2c master transfer sequencer: input register, context
// registers, write buffer and result register; uses i2cmts_pkg, i2cmts_decide
//
// Usage: items arrive on the s_ group, s_tuser gives the kind (load byte,
// start transfer, controller interrupt) and s_tdata the rest. Each accepted
// item produces exactly one result on the m_ group: m_tuser tells whether a
// byte goes to the data register or was received, m_tdata carries the
// control-bit actions, completion and outcome.
// An accepted item is decided from the input register and its result is
// registered when the result register may advance, together with any
// byte to send, read from the 256 x 8 write buffer (registered read port).
// Throughput is one item per cycle while the receiver does not stall; the
// path is the status-code decode plus the counter bump and its compares.
// Reset clears the context (counter, length, address, direction) and both
// valid flags; the buffer is not cleared and needs no clearing pass, a
// byte sent from an entry never loaded is undefined.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; s_tready drops only when both are full.
module i2c_master_transfer_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // action
  input  logic [1:0]                     s_tuser,
  // index, data_byte, slave_address, length, direction, irq_flag,
  // status_code, zero fill
  input  logic [i2cmts_pkg::S_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // byte_kind
  output logic [1:0]                     m_tuser,
  // handled, byte_value, byte_index, clear_all, set_start, clear_start,
  // clear_irq, set_stop, ack_control, done_res, outcome, zero fill
  output logic [i2cmts_pkg::M_DATA_W-1:0] m_tdata
);
  import i2cmts_pkg::*;

  item_t    in_item;
  item_t    a_item;
  logic     a_valid;
  ctx_t     ctx;
  ctx_t     ctx_next;
  res_t     res_next;
  res_t     res;
  mem_req_t mem_req;
  logic     out_valid;
  logic     adv_out;
  logic     fire_a;
  logic [7:0] wbuf [BUF_DEPTH];
  logic [7:0] wbuf_q;
  logic [7:0] out_byte;

  // unpack the input transfer
  assign in_item.action        = s_tuser;
  assign in_item.index         = s_tdata[7:0];
  assign in_item.data_byte     = s_tdata[15:8];
  assign in_item.slave_address = s_tdata[23:16];
  assign in_item.length        = s_tdata[32:24];
  assign in_item.direction     = s_tdata[34:33];
  assign in_item.irq_flag      = s_tdata[35];
  assign in_item.status_code   = s_tdata[43:36];

  // pipeline handshake
  assign adv_out  = !out_valid || m_tready;
  assign fire_a   = a_valid && adv_out;
  assign s_tready = !a_valid || adv_out;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_item <= in_item;
    end
  end

  i2cmts_decide u_decide (
    .item     (a_item),
    .ctx      (ctx),
    .res      (res_next),
    .ctx_next (ctx_next),
    .mem_req  (mem_req)
  );

  // transfer context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (fire_a) begin
      ctx <= ctx_next;
    end
  end

  // write buffer, registered read port
  always_ff @(posedge clk) begin
    if (fire_a && mem_req.wr_en) begin
      wbuf[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (fire_a && mem_req.rd_en) begin
      wbuf_q <= wbuf[mem_req.rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      res <= res_next;
    end
  end

  // pack the output transfer
  assign out_byte = res.use_mem ? wbuf_q : res.byte_value;
  assign m_tvalid = out_valid;
  assign m_tuser  = res.byte_kind;
  assign m_tdata  = {5'd0, res.outcome, res.done_res, res.ack_control, res.set_stop,
                     res.clear_irq, res.clear_start, res.set_start, res.clear_all,
                     res.byte_index, out_byte, res.handled};

endmodule

@@ hw/rtl/i2cmts_decide.sv @@
// decision logic: one item plus the transfer context gives the result,
// the next context and the write buffer access; uses i2cmts_pkg
module i2cmts_decide (
  input  i2cmts_pkg::item_t    item,
  input  i2cmts_pkg::ctx_t     ctx,
  output i2cmts_pkg::res_t     res,
  output i2cmts_pkg::ctx_t     ctx_next,
  output i2cmts_pkg::mem_req_t mem_req
);
  import i2cmts_pkg::*;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W:0]   cnt_inc_p1;
  logic [CNT_W:0]   cnt_p1;
  logic [CNT_W-1:0] wr_cnt;
  logic             wr_cnt_in_buf;

  // saturating counter bump and the compares built on it
  assign cnt_inc    = (ctx.byte_counter == CNT_MAX) ? CNT_MAX
                                                    : ctx.byte_counter + 1'b1;
  assign cnt_p1     = {1'b0, ctx.byte_counter} + 1'b1;
  assign cnt_inc_p1 = {1'b0, cnt_inc} + 1'b1;
  assign wr_cnt     = (item.status_code == ST_WDATA_ACK) ? cnt_inc : ctx.byte_counter;
  assign wr_cnt_in_buf = (wr_cnt < CNT_W'(BUF_DEPTH));

  always_comb begin
    res      = '0;
    res.handled = 1'b1;
    ctx_next = ctx;
    mem_req  = '0;
    mem_req.wr_addr = item.index[BUF_AW-1:0];
    mem_req.wr_data = item.data_byte;
    mem_req.rd_addr = wr_cnt[BUF_AW-1:0];

    case (item.action)
      ACT_LOAD: begin
        mem_req.wr_en = (item.index < 8'(BUF_DEPTH - 1)) ||
                        (item.index == 8'(BUF_DEPTH - 1));
      end
      ACT_START: begin
        ctx_next.stored_address   = item.slave_address;
        ctx_next.stored_length    = item.length;
        ctx_next.stored_direction = item.direction;
        ctx_next.byte_counter     = '0;
        res.set_start   = 1'b1;
        res.ack_control = AA_SET;
      end
      ACT_IRQ: begin
        if (!item.irq_flag) begin
          res.handled = 1'b0;
        end else if (ctx.stored_direction == DIR_READ) begin
          // master receiver sequencing
          case (item.status_code)
            ST_START_SENT: begin
              res.byte_kind   = BK_SEND;
              res.byte_value  = ctx.stored_address;
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
            end
            ST_RADDR_ACK: begin
              res.clear_irq   = 1'b1;
              res.ack_control = (cnt_p1 < {1'b0, ctx.stored_length}) ? AA_SET : AA_CLEAR;
            end
            ST_RADDR_NACK: begin
              res.clear_irq = 1'b1;
              res.set_stop  = 1'b1;
              res.done_res  = 1'b1;
              res.outcome   = OUT_NOREPLY;
            end
            ST_RDATA_ACK, ST_RDATA_NACK: begin
              if (ctx.byte_counter < CNT_W'(BUF_DEPTH)) begin
                res.byte_kind  = BK_RECV;
                res.byte_value = item.data_byte;
                res.byte_index = ctx.byte_counter[7:0];
              end
              ctx_next.byte_counter = cnt_inc;
              res.clear_irq = 1'b1;
              if (item.status_code == ST_RDATA_ACK) begin
                res.ack_control = (cnt_inc_p1 < {1'b0, ctx.stored_length}) ? AA_SET
                                                                            : AA_CLEAR;
              end else begin
                res.ack_control = AA_SET;
                res.set_stop    = 1'b1;
                res.done_res    = 1'b1;
                res.outcome     = OUT_OK;
              end
            end
            default: begin
              res.clear_all = 1'b1;
              res.done_res  = 1'b1;
              res.outcome   = OUT_BUSY;
            end
          endcase
        end else if (ctx.stored_direction == DIR_WRITE) begin
          // master transmitter sequencing
          case (item.status_code)
            ST_START_SENT: begin
              res.byte_kind   = BK_SEND;
              res.byte_value  = ctx.stored_address;
              res.clear_start = 1'b1;
              res.clear_irq   = 1'b1;
            end
            ST_WADDR_ACK, ST_WDATA_ACK: begin
              res.clear_start = (item.status_code == ST_WADDR_ACK);
              ctx_next.byte_counter = wr_cnt;
              res.clear_irq = 1'b1;
              if (wr_cnt < ctx.stored_length) begin
                res.byte_kind = BK_SEND;
                res.use_mem   = wr_cnt_in_buf;
                mem_req.rd_en = wr_cnt_in_buf;
              end else begin
                res.set_stop = 1'b1;
              end
              if (wr_cnt == ctx.stored_length) begin
                res.done_res = 1'b1;
                res.outcome  = OUT_OK;
              end
            end
            ST_WADDR_NACK: begin
              res.set_stop = 1'b1;
              res.done_res = 1'b1;
              res.outcome  = OUT_NOREPLY;
            end
            default: begin
              res.clear_all = 1'b1;
              res.done_res  = 1'b1;
              res.outcome   = OUT_BUSY;
            end
          endcase
        end else begin
          // no transfer set up: release the controller
          res.clear_all = 1'b1;
          res.done_res  = 1'b1;
          res.outcome   = OUT_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/i2cmts_port_check.sv @@
// port-level checks for the i2c master transfer sequencer and their binding
// depends on i2cmts_pkg and the top level's ports
module i2cmts_port_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [1:0]                      m_tuser,
  input logic [i2cmts_pkg::M_DATA_W-1:0] m_tdata
);
  import i2cmts_pkg::*;

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an unhandled interrupt carries no action at all
  a_unhandled_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == '0 && m_tuser == BK_NONE)
    else $error("unhandled result with actions");

  // outcome only with completion
  a_outcome_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[24] |-> m_tdata[26:25] == OUT_OK)
    else $error("outcome without completion");

  // no byte, no byte value and index
  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == BK_NONE |-> m_tdata[16:1] == '0)
    else $error("byte fields set with no byte");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind i2c_master_transfer_sequencer i2cmts_port_check u_port_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

@@ bench/i2cmts_action_checker.sv @@
// port checker for the i2c master transfer sequencer: watches both stream
// channels, predicts every bus action and compares it field by field
// depends on i2cmts_pkg for item kinds, status codes and result codes
module i2cmts_action_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // action
  input  logic [1:0]                      s_tuser,
  // index, data_byte, slave_address, length, direction, irq_flag,
  // status_code, zero fill
  input  logic [i2cmts_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // byte_kind
  input  logic [1:0]                      m_tuser,
  // handled, byte_value, byte_index, clear_all, set_start, clear_start,
  // clear_irq, set_stop, ack_control, done_res, outcome, zero fill
  input  logic [i2cmts_pkg::M_DATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmts_pkg::*;

  // predicted answer for one item
  typedef struct packed {
    logic       handled;
    logic [1:0] byte_kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       clear_all;
    logic       set_start;
    logic       clear_start;
    logic       clear_irq;
    logic       set_stop;
    logic [1:0] ack_control;
    logic       done_res;
    logic [1:0] outcome;
  } bus_action_t;

  // shadow of the transfer context and the write buffer
  logic [7:0]       tx_bytes [BUF_DEPTH];
  logic [CNT_W-1:0] xfer_count;
  logic [CNT_W-1:0] xfer_len;
  logic [7:0]       xfer_addr;
  logic [1:0]       xfer_dir;

  bus_action_t bus_actions_q[$];
  bus_action_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // byte counter stops at its top value
  function automatic void bump_count();
    if (xfer_count != CNT_MAX) xfer_count = xfer_count + 1'b1;
  endfunction

  // keep acknowledging while more than one byte is still to come
  function automatic logic [1:0] ack_for_next();
    return ({1'b0, xfer_count} + 10'd1 < {1'b0, xfer_len}) ? AA_SET : AA_CLEAR;
  endfunction

  function automatic bus_action_t decide_bus_action(input logic [1:0] act,
                                                    input logic [S_DATA_W-1:0] f);
    logic [7:0]       idx;
    logic [7:0]       dat;
    logic [7:0]       adr;
    logic [CNT_W-1:0] len;
    logic [1:0]       dir;
    logic             si;
    logic [7:0]       st;
    bus_action_t      r;
    idx = f[7:0];
    dat = f[15:8];
    adr = f[23:16];
    len = f[32:24];
    dir = f[34:33];
    si  = f[35];
    st  = f[43:36];
    r = '0;
    r.handled = 1'b1;
    case (act)
      ACT_LOAD: begin
        tx_bytes[idx] = dat;
      end
      ACT_START: begin
        xfer_addr  = adr;
        xfer_len   = len;
        xfer_dir   = dir;
        xfer_count = '0;
        r.set_start   = 1'b1;
        r.ack_control = AA_SET;
      end
      ACT_IRQ: begin
        if (!si) begin
          // interrupt raised by some other controller
          r.handled = 1'b0;
        end else if (xfer_dir == DIR_READ) begin
          case (st)
            ST_START_SENT: begin
              r.byte_kind   = BK_SEND;
              r.byte_value  = xfer_addr;
              r.clear_start = 1'b1;
              r.clear_irq   = 1'b1;
            end
            ST_RADDR_ACK: begin
              r.clear_irq   = 1'b1;
              r.ack_control = ack_for_next();
            end
            ST_RADDR_NACK: begin
              r.clear_irq = 1'b1;
              r.set_stop  = 1'b1;
              r.done_res  = 1'b1;
              r.outcome   = OUT_NOREPLY;
            end
            ST_RDATA_ACK, ST_RDATA_NACK: begin
              // bytes beyond the buffer are dropped but still counted
              if (xfer_count < BUF_DEPTH) begin
                r.byte_kind  = BK_RECV;
                r.byte_value = dat;
                r.byte_index = xfer_count[7:0];
              end
              bump_count();
              r.clear_irq = 1'b1;
              if (st == ST_RDATA_ACK) begin
                r.ack_control = ack_for_next();
              end else begin
                r.ack_control = AA_SET;
                r.set_stop    = 1'b1;
                r.done_res    = 1'b1;
                r.outcome     = OUT_OK;
              end
            end
            default: begin
              r.clear_all = 1'b1;
              r.done_res  = 1'b1;
              r.outcome   = OUT_BUSY;
            end
          endcase
        end else if (xfer_dir == DIR_WRITE) begin
          case (st)
            ST_START_SENT: begin
              r.byte_kind   = BK_SEND;
              r.byte_value  = xfer_addr;
              r.clear_start = 1'b1;
              r.clear_irq   = 1'b1;
            end
            ST_WADDR_ACK, ST_WDATA_ACK: begin
              if (st == ST_WADDR_ACK) r.clear_start = 1'b1;
              else bump_count();
              r.clear_irq = 1'b1;
              if (xfer_count < xfer_len) begin
                r.byte_kind  = BK_SEND;
                r.byte_value = (xfer_count < BUF_DEPTH) ? tx_bytes[xfer_count[7:0]] : 8'h00;
              end else begin
                r.set_stop = 1'b1;
              end
              if (xfer_count == xfer_len) begin
                r.done_res = 1'b1;
                r.outcome  = OUT_OK;
              end
            end
            ST_WADDR_NACK: begin
              // SI stays set, only STOP is requested
              r.set_stop = 1'b1;
              r.done_res = 1'b1;
              r.outcome  = OUT_NOREPLY;
            end
            default: begin
              r.clear_all = 1'b1;
              r.done_res  = 1'b1;
              r.outcome   = OUT_BUSY;
            end
          endcase
        end else begin
          // no transfer under way: clear the controller and finish
          r.clear_all = 1'b1;
          r.done_res  = 1'b1;
          r.outcome   = OUT_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // results are popped before new items are pushed
  always @(posedge clk) begin
    if (rst) begin
      xfer_count = '0;
      xfer_len   = '0;
      xfer_addr  = '0;
      xfer_dir   = '0;
      bus_actions_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (bus_actions_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          want = bus_actions_q.pop_front();
          check_field("handled",     want.handled,     m_tdata[0]);
          check_field("byte_kind",   want.byte_kind,   m_tuser);
          check_field("byte_value",  want.byte_value,  m_tdata[8:1]);
          check_field("byte_index",  want.byte_index,  m_tdata[16:9]);
          check_field("clear_all",   want.clear_all,   m_tdata[17]);
          check_field("set_start",   want.set_start,   m_tdata[18]);
          check_field("clear_start", want.clear_start, m_tdata[19]);
          check_field("clear_irq",   want.clear_irq,   m_tdata[20]);
          check_field("set_stop",    want.set_stop,    m_tdata[21]);
          check_field("ack_control", want.ack_control, m_tdata[23:22]);
          check_field("done_res",    want.done_res,    m_tdata[24]);
          check_field("outcome",     want.outcome,     m_tdata[26:25]);
        end
      end
      if (s_tvalid && s_tready)
        bus_actions_q.push_back(decide_bus_action(s_tuser, s_tdata));
    end
    pending = bus_actions_q.size();
  end

endmodule

@@ bench/tb_i2c_master_transfer_sequencer.sv @@
// stimulus and verdict for the i2c master transfer sequencer: directed
// transfers, then random well-formed sequences mixed with noise items
// depends on i2cmts_pkg, the sequencer rtl and i2cmts_action_checker
module tb_i2c_master_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmts_pkg::*;

  localparam int         ITEM_TOTAL  = 1450;
  localparam int         STALL_LIMIT = 3000;
  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_SPARE   = 2'd3;
  localparam logic [71:0] KNOWN_CODES = {ST_START_SENT, ST_WADDR_ACK, ST_WADDR_NACK,
                                         ST_WDATA_ACK, ST_WDATA_NACK, ST_RADDR_ACK,
                                         ST_RADDR_NACK, ST_RDATA_ACK, ST_RDATA_NACK};

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [1:0]          s_tuser  = '0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [1:0]          m_tuser;
  logic [M_DATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int items_sent   = 0;
  int tx_idle_pct  = 38;
  int rx_idle_pct  = 52;
  int stall_cycles = 0;
  bit buf_loaded [BUF_DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_transfer_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  i2cmts_action_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tuser    (m_tuser),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [S_DATA_W-1:0] pack_item(
      input logic [7:0] idx, input logic [7:0] dat, input logic [7:0] adr,
      input logic [CNT_W-1:0] len, input logic [1:0] dir, input logic si,
      input logic [7:0] st);
    return {4'b0, st, si, dir, len, adr, dat, idx};
  endfunction

  function automatic logic [CNT_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 88) return CNT_W'($urandom_range(6));
    if (r < 98) return CNT_W'($urandom_range(40, 7));
    return CNT_W'($urandom_range(256, 200));
  endfunction

  // one input transfer, with random idle cycles in front
  task automatic push_item(input logic [1:0] act, input logic [S_DATA_W-1:0] f);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending until every result is back; returns at a falling edge
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic load_byte(input logic [7:0] idx, input logic [7:0] val);
    push_item(ACT_LOAD, pack_item(idx, val, 8'($urandom), CNT_W'($urandom_range(256)),
                                  2'($urandom), 1'($urandom), 8'($urandom)));
    buf_loaded[idx] = 1'b1;
  endtask

  // a write never sends a buffer entry that was not loaded first
  task automatic start_xfer(input logic [7:0] adr, input logic [CNT_W-1:0] len,
                            input logic [1:0] dir);
    for (int i = 0; i < len; i++)
      if (!buf_loaded[i]) load_byte(8'(i), 8'($urandom));
    push_item(ACT_START, pack_item(8'($urandom), 8'($urandom), adr, len, dir,
                                   1'($urandom), 8'($urandom)));
  endtask

  task automatic irq_event(input logic si, input logic [7:0] st, input logic [7:0] dat);
    push_item(ACT_IRQ, pack_item(8'($urandom), dat, 8'($urandom),
                                 CNT_W'($urandom_range(256)), 2'($urandom), si, st));
  endtask

  // controller interrupt, now and then preceded by one from another source
  task automatic irq(input logic [7:0] st);
    if ($urandom_range(39) == 0) irq_event(1'b0, 8'($urandom), 8'($urandom));
    irq_event(1'b1, st, 8'($urandom));
  endtask

  task automatic write_seq(input logic [CNT_W-1:0] len);
    logic [7:0] adr;
    adr = 8'($urandom);
    adr[0] = 1'b0;
    start_xfer(adr, len, DIR_WRITE);
    irq(ST_START_SENT);
    if ($urandom_range(19) == 0) begin
      irq(ST_WADDR_NACK);
      return;
    end
    irq(ST_WADDR_ACK);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(29) == 0) begin
        irq(ST_WDATA_NACK);
        return;
      end
      irq(ST_WDATA_ACK);
    end
    // extra ack after the last byte
    if ($urandom_range(9) == 0) irq(ST_WDATA_ACK);
  endtask

  task automatic read_seq(input logic [CNT_W-1:0] len, input int nbytes);
    logic [7:0] adr;
    adr = 8'($urandom);
    adr[0] = 1'b1;
    start_xfer(adr, len, DIR_READ);
    irq(ST_START_SENT);
    if ($urandom_range(19) == 0) begin
      irq(ST_RADDR_NACK);
      return;
    end
    irq(ST_RADDR_ACK);
    for (int k = 1; k < nbytes; k++) irq(ST_RDATA_ACK);
    irq(ST_RDATA_NACK);
  endtask

  task automatic noise_item();
    logic [1:0] act;
    logic [7:0] st;
    act = 2'($urandom_range(3));
    st  = $urandom_range(1) ? KNOWN_CODES[8*$urandom_range(8) +: 8] : 8'($urandom);
    case (act)
      ACT_LOAD:  load_byte(8'($urandom), 8'($urandom));
      ACT_START: start_xfer(8'($urandom), pick_len(), 2'($urandom_range(3)));
      default:   push_item(act, pack_item(8'($urandom), 8'($urandom), 8'($urandom),
                                          CNT_W'($urandom_range(256)),
                                          2'($urandom_range(3)), 1'($urandom), st));
    endcase
  endtask

  initial begin
    int phase;
    int want_phase;
    int r;
    int n;
    bit long_read_done;
    phase = 0;
    long_read_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: buffer index extremes and byte extremes
    load_byte(8'd0, 8'h00);
    load_byte(8'd1, 8'hFF);
    load_byte(8'd255, 8'hA5);
    // interrupt without SI, then with no transfer set up
    irq_event(1'b0, ST_START_SENT, 8'hFF);
    irq_event(1'b1, 8'h00, 8'h00);
    // unused action code
    push_item(ACT_SPARE, pack_item(8'hFF, 8'hFF, 8'hFF, 9'd256, DIR_SPARE, 1'b1, 8'hFF));
    // complete write, then one ack past the end
    start_xfer(8'hFE, 9'd2, DIR_WRITE);
    irq_event(1'b1, ST_START_SENT, 8'h00);
    irq_event(1'b1, ST_WADDR_ACK, 8'h00);
    irq_event(1'b1, ST_WDATA_ACK, 8'h00);
    irq_event(1'b1, ST_WDATA_ACK, 8'h00);
    irq_event(1'b1, ST_WDATA_ACK, 8'h00);
    // write address not acknowledged, data not acknowledged
    start_xfer(8'h00, 9'd1, DIR_WRITE);
    irq_event(1'b1, ST_WADDR_NACK, 8'h00);
    start_xfer(8'h00, 9'd1, DIR_WRITE);
    irq_event(1'b1, ST_WADDR_ACK, 8'h00);
    irq_event(1'b1, ST_WDATA_NACK, 8'h00);
    // zero-length read: no ack after the address
    start_xfer(8'hFF, 9'd0, DIR_READ);
    irq_event(1'b1, ST_START_SENT, 8'h00);
    irq_event(1'b1, ST_RADDR_ACK, 8'h00);
    irq_event(1'b1, ST_RDATA_NACK, 8'hFF);
    // longest read, cut short by a missing address ack
    start_xfer(8'h01, 9'd256, DIR_READ);
    irq_event(1'b1, ST_RADDR_ACK, 8'h00);
    irq_event(1'b1, ST_RDATA_ACK, 8'h00);
    irq_event(1'b1, ST_RADDR_NACK, 8'h00);
    // unknown status code in a read, spare direction
    start_xfer(8'h01, 9'd2, DIR_READ);
    irq_event(1'b1, 8'hFF, 8'h00);
    start_xfer(8'h55, 9'd256, DIR_SPARE);
    irq_event(1'b1, ST_WDATA_ACK, 8'h00);

    // random sequences until the item budget is used
    while (items_sent < ITEM_TOTAL) begin
      want_phase = (items_sent < ITEM_TOTAL / 3) ? 0 :
                   (items_sent < 2 * ITEM_TOTAL / 3) ? 1 : 2;
      if (want_phase != phase) begin
        drain_results();
        phase = want_phase;
        tx_idle_pct = (phase == 1) ? 52 : 0;
        rx_idle_pct = (phase == 1) ? 38 : 0;
        @(posedge clk);
      end
      if (!long_read_done && items_sent > ITEM_TOTAL / 2) begin
        // runs the byte counter past the buffer and into saturation
        read_seq(9'd256, 515);
        long_read_done = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 36) begin
        write_seq(pick_len());
      end else if (r < 72) begin
        n = pick_len();
        read_seq(CNT_W'(n), n);
      end else if (r < 77) begin
        start_xfer(8'($urandom), pick_len(), $urandom_range(1) ? DIR_NONE : DIR_SPARE);
        irq(8'($urandom));
      end else begin
        noise_item();
      end
      if ($urandom_range(49) == 0) begin
        drain_results();
        @(posedge clk);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/i2cmts_pkg.sv
hw/rtl/i2cmts_decide.sv
hw/rtl/i2c_master_transfer_sequencer.sv
hw/rtl/i2cmts_port_check.sv
bench/i2cmts_action_checker.sv
bench/tb_i2c_master_transfer_sequencer.sv
